/* hw/rtl/gmcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmcs_pkg
// Types and constants shared by the gyro median calibrate and scale core.
// ----------------------------------------------------------------------------
package gmcs_pkg;

  localparam int CAL_SAMPLES = 16;
  localparam int NUM_AXES    = 3;
  localparam int WORD_W      = 16;
  localparam int RATE_W      = 12;
  localparam int IDX_W       = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
  localparam int CNT_W       = $clog2(CAL_SAMPLES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // x / 131 == (x * 64036) >> 23 for 0 <= x <= 32768
  localparam int DIV_MUL_W = 17;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 17'd64036;
  localparam int DIV_SHIFT = 23;
  localparam int PROD_W    = WORD_W + DIV_MUL_W;
  localparam int Q_W       = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_RANGE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WORD0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WORD1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WORD2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_CAL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAN_OFFSET_X = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAN_OFFSET_Y = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAN_OFFSET_Z = 3'd7;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic KIND_COLLECT = 1'b0;
  localparam logic KIND_RESULT  = 1'b1;

  typedef logic [NUM_AXES-1:0][WORD_W-1:0] axes_t;

  typedef struct packed {
    logic [1:0]                gyro_range;
    logic [NUM_AXES-1:0][1:0]  map_word;
    logic                      skip_calibration;
    axes_t                     manual_offset;
  } cfg_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word_first;
    logic signed [WORD_W-1:0] word_second;
    logic signed [WORD_W-1:0] word_third;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] corrected_x;
    logic signed [WORD_W-1:0] corrected_y;
    logic signed [WORD_W-1:0] corrected_z;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
  } out_item_t;

  typedef struct packed {
    logic             kind;
    logic             last;
    logic [IDX_W-1:0] idx;
    axes_t            axes;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

/* hw/rtl/gmcs_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmcs_in_if
// Valid/ready channel carrying one set of raw sensor words per beat.
// ----------------------------------------------------------------------------
interface gmcs_in_if;
  logic               valid;
  logic               ready;
  gmcs_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/gmcs_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmcs_out_if
// Valid/ready channel carrying one corrected, scaled sample per beat.
// ----------------------------------------------------------------------------
interface gmcs_out_if;
  logic                valid;
  logic                ready;
  gmcs_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/gmcs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmcs_front
// Accepts sensor beats, routes words to axes and tags each beat as a
// calibration sample or a result sample.
// ----------------------------------------------------------------------------
module gmcs_front (
  input  logic               clk,
  input  logic               rst,
  gmcs_in_if.sink            samples,
  input  gmcs_pkg::cfg_t     cfg,
  input  logic               q_full,
  output gmcs_pkg::q_push_t  q_push
);

  logic [gmcs_pkg::CNT_W-1:0] count;
  logic                       collecting;
  gmcs_pkg::axes_t            routed;
  logic [gmcs_pkg::NUM_AXES-1:0][gmcs_pkg::WORD_W-1:0] words;

  assign words = {samples.payload.word_third, samples.payload.word_second,
                  samples.payload.word_first};

  always_comb begin
    routed = '0;
    for (int i = 0; i < gmcs_pkg::NUM_AXES; i++) begin
      case (cfg.map_word[i])
        gmcs_pkg::AXIS_X: routed[0] = words[i];
        gmcs_pkg::AXIS_Y: routed[1] = words[i];
        gmcs_pkg::AXIS_Z: routed[2] = words[i];
        default: ;
      endcase
    end
  end

  assign collecting = !cfg.skip_calibration &&
                      (count != gmcs_pkg::CNT_W'(gmcs_pkg::CAL_SAMPLES));

  assign samples.ready = !q_full;

  always_comb begin
    q_push.push       = samples.valid && !q_full;
    q_push.entry.kind = collecting ? gmcs_pkg::KIND_COLLECT : gmcs_pkg::KIND_RESULT;
    q_push.entry.last = (count == gmcs_pkg::CNT_W'(gmcs_pkg::CAL_SAMPLES - 1));
    q_push.entry.idx  = count[gmcs_pkg::IDX_W-1:0];
    q_push.entry.axes = routed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (q_push.push && collecting) begin
      count <= count + 1'b1;
    end
  end

endmodule

/* hw/rtl/gmcs_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmcs_queue
// Short FIFO of tagged beats between the front and the back.
// ----------------------------------------------------------------------------
module gmcs_queue (
  input  logic               clk,
  input  logic               rst,
  input  gmcs_pkg::q_push_t  q_push,
  input  logic               pop,
  output logic               full,
  output gmcs_pkg::q_head_t  head
);

  gmcs_pkg::q_entry_t          ent [gmcs_pkg::QUEUE_DEPTH];
  logic [gmcs_pkg::QPTR_W-1:0] wr_ptr;
  logic [gmcs_pkg::QPTR_W-1:0] rd_ptr;
  logic [gmcs_pkg::QCNT_W-1:0] fill;
  logic                        empty;

  assign empty = (fill == '0);
  assign full  = (fill == gmcs_pkg::QCNT_W'(gmcs_pkg::QUEUE_DEPTH));

  assign head.valid = !empty;
  assign head.entry = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      ent[wr_ptr] <= q_push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (q_push.push) begin
        wr_ptr <= (wr_ptr == gmcs_pkg::QPTR_W'(gmcs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == gmcs_pkg::QPTR_W'(gmcs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (q_push.push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !q_push.push) begin
        fill <= fill - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push.push && full && !pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("queue pop while empty");
`endif

endmodule

/* hw/rtl/gmcs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmcs_back
// Stores calibration samples, finds the per-axis upper median by rank
// counting, and turns result samples into corrected words and rates.
// ----------------------------------------------------------------------------
module gmcs_back (
  input  logic               clk,
  input  logic               rst,
  input  gmcs_pkg::cfg_t     cfg,
  input  gmcs_pkg::q_head_t  head,
  output logic               pop,
  gmcs_out_if.source         results
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MUL     = 3'd1;
  localparam logic [2:0] ST_OUT     = 3'd2;
  localparam logic [2:0] ST_MED     = 3'd3;
  localparam logic [2:0] ST_MED_END = 3'd4;

  localparam logic [gmcs_pkg::IDX_W-1:0] LAST_IDX = gmcs_pkg::IDX_W'(gmcs_pkg::CAL_SAMPLES - 1);
  localparam logic [gmcs_pkg::IDX_W-1:0] MED_RANK = gmcs_pkg::IDX_W'(gmcs_pkg::CAL_SAMPLES / 2);

  logic [2:0] state;

  gmcs_pkg::axes_t mem [gmcs_pkg::CAL_SAMPLES];
  gmcs_pkg::axes_t rd_i;
  gmcs_pkg::axes_t rd_j;

  logic [gmcs_pkg::IDX_W-1:0] ci;
  logic [gmcs_pkg::IDX_W-1:0] cj;
  logic                       pv;
  logic [gmcs_pkg::IDX_W-1:0] pi;
  logic [gmcs_pkg::IDX_W-1:0] pj;
  logic [gmcs_pkg::NUM_AXES-1:0][gmcs_pkg::IDX_W-1:0] rank;
  logic [gmcs_pkg::NUM_AXES-1:0][gmcs_pkg::IDX_W-1:0] rank_next;

  gmcs_pkg::axes_t bias;
  gmcs_pkg::axes_t offset;

  gmcs_pkg::axes_t                                     corr;
  logic [gmcs_pkg::NUM_AXES-1:0]                       neg;
  logic [gmcs_pkg::NUM_AXES-1:0][gmcs_pkg::WORD_W-1:0] mag;
  logic [gmcs_pkg::NUM_AXES-1:0][gmcs_pkg::Q_W-1:0]    quot;

  gmcs_pkg::axes_t                                     diff;
  logic [gmcs_pkg::NUM_AXES-1:0][gmcs_pkg::PROD_W-1:0] prod;
  logic [gmcs_pkg::NUM_AXES-1:0][gmcs_pkg::RATE_W-1:0] scaled;
  logic [gmcs_pkg::NUM_AXES-1:0][gmcs_pkg::RATE_W-1:0] rate;

  logic out_valid;
  logic out_load;
  gmcs_pkg::out_item_t out_data;

  assign pop      = (state == ST_IDLE) && head.valid;
  assign out_load = (state == ST_OUT) && (!out_valid || results.ready);
  assign offset   = cfg.skip_calibration ? cfg.manual_offset : bias;

  always_comb begin
    for (int a = 0; a < gmcs_pkg::NUM_AXES; a++) begin
      diff[a]   = head.entry.axes[a] - offset[a];
      prod[a]   = gmcs_pkg::PROD_W'(mag[a]) * gmcs_pkg::PROD_W'(gmcs_pkg::DIV_MUL);
      scaled[a] = gmcs_pkg::RATE_W'(quot[a]) << cfg.gyro_range;
      rate[a]   = neg[a] ? -scaled[a] : scaled[a];
    end
  end

  // stable rank: smaller values, plus equal values at lower indexes
  always_comb begin
    for (int a = 0; a < gmcs_pkg::NUM_AXES; a++) begin
      rank_next[a] = ((pj == '0) ? '0 : rank[a]) + gmcs_pkg::IDX_W'(
        ($signed(rd_j[a]) < $signed(rd_i[a])) ||
        ((rd_j[a] == rd_i[a]) && (pj < pi)));
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (head.entry.kind == gmcs_pkg::KIND_COLLECT)) begin
      mem[head.entry.idx] <= head.entry.axes;
    end
    rd_i <= mem[ci];
    rd_j <= mem[cj];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ci        <= '0;
      cj        <= '0;
      pv        <= 1'b0;
      bias      <= '0;
      out_valid <= 1'b0;
    end else begin
      pv <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (pop) begin
            if (head.entry.kind == gmcs_pkg::KIND_RESULT) begin
              state <= ST_MUL;
            end else if (head.entry.last) begin
              ci    <= '0;
              cj    <= '0;
              state <= ST_MED;
            end
          end
        end
        ST_MUL: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        ST_MED: begin
          pv <= 1'b1;
          if (cj == LAST_IDX) begin
            cj <= '0;
            ci <= ci + 1'b1;
            if (ci == LAST_IDX) begin
              state <= ST_MED_END;
            end
          end else begin
            cj <= cj + 1'b1;
          end
        end
        ST_MED_END: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (pv && (pj == LAST_IDX)) begin
        for (int a = 0; a < gmcs_pkg::NUM_AXES; a++) begin
          if (rank_next[a] == MED_RANK) begin
            bias[a] <= rd_i[a];
          end
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pi   <= ci;
    pj   <= cj;
    rank <= rank_next;
    if (pop) begin
      for (int a = 0; a < gmcs_pkg::NUM_AXES; a++) begin
        corr[a] <= diff[a];
        neg[a]  <= diff[a][gmcs_pkg::WORD_W-1];
        mag[a]  <= diff[a][gmcs_pkg::WORD_W-1] ? -diff[a] : diff[a];
      end
    end
    if (state == ST_MUL) begin
      for (int a = 0; a < gmcs_pkg::NUM_AXES; a++) begin
        quot[a] <= prod[a][gmcs_pkg::DIV_SHIFT +: gmcs_pkg::Q_W];
      end
    end
    if (out_load) begin
      out_data.corrected_x <= corr[0];
      out_data.corrected_y <= corr[1];
      out_data.corrected_z <= corr[2];
      out_data.rate_x      <= rate[0];
      out_data.rate_y      <= rate[1];
      out_data.rate_z      <= rate[2];
    end
  end

  assign results.valid   = out_valid;
  assign results.payload = out_data;

`ifndef ASSERT_OFF
  a_bias_only_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(bias)) |->
      ($past(state) == ST_MED || $past(state) == ST_MED_END))
    else $error("bias changed outside median sweep");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(results.valid)) |-> ($past(state) == ST_OUT))
    else $error("result beat raised outside output step");
`endif

endmodule

/* hw/rtl/gyro_median_calibrate_and_scale_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_median_calibrate_and_scale_core
// Gyro bias removal by upper-median calibration, then scaling to deg/s.
// ----------------------------------------------------------------------------
// A result beat passes through the queue, then the back's diff, multiply and
// output steps; the output step waits while a held result is not yet taken,
// and the back pops no new beat until it loads that result. Calibration beats
// are stored from the idle state; the last starts a median sweep over all
// CAL_SAMPLES*CAL_SAMPLES pairs via the memory's two read ports. Reset clears
// configuration, count, bias and queue; the sample memory is not cleared.
// ----------------------------------------------------------------------------
module gyro_median_calibrate_and_scale_core (
  input  logic                              clk,
  input  logic                              rst,
  gmcs_in_if.sink                           samples,
  gmcs_out_if.source                        results,
  input  logic                              cfg_we,
  input  logic [gmcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gmcs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  gmcs_pkg::cfg_t    cfg;
  gmcs_pkg::q_push_t q_push;
  gmcs_pkg::q_head_t head;
  logic              q_full;
  logic              pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gyro_range       <= 2'd3;
      cfg.map_word[0]      <= gmcs_pkg::AXIS_X;
      cfg.map_word[1]      <= gmcs_pkg::AXIS_Y;
      cfg.map_word[2]      <= gmcs_pkg::AXIS_Z;
      cfg.skip_calibration <= 1'b0;
      cfg.manual_offset    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gmcs_pkg::REG_GYRO_RANGE:   cfg.gyro_range       <= cfg_data[1:0];
        gmcs_pkg::REG_MAP_WORD0:    cfg.map_word[0]      <= cfg_data[1:0];
        gmcs_pkg::REG_MAP_WORD1:    cfg.map_word[1]      <= cfg_data[1:0];
        gmcs_pkg::REG_MAP_WORD2:    cfg.map_word[2]      <= cfg_data[1:0];
        gmcs_pkg::REG_SKIP_CAL:     cfg.skip_calibration <= cfg_data[0];
        gmcs_pkg::REG_MAN_OFFSET_X: cfg.manual_offset[0] <= cfg_data;
        gmcs_pkg::REG_MAN_OFFSET_Y: cfg.manual_offset[1] <= cfg_data;
        gmcs_pkg::REG_MAN_OFFSET_Z: cfg.manual_offset[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  gmcs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push)
  );

  gmcs_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .pop    (pop),
    .full   (q_full),
    .head   (head)
  );

  gmcs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule
